FILE: rtl/mqbf_pkg.sv
// ----------------------------------------------------------------------------
// mqbf_pkg: shared types and constants of the multi-queue byte FIFO
// Queue geometry, command and status codes, and the request and response
// word layouts.
// ----------------------------------------------------------------------------
package mqbf_pkg;

  // Queue geometry
  localparam int QUEUE_COUNT = 4;     // 1 .. 8
  localparam int QUEUE_DEPTH = 256;   // 2 .. 511

  localparam int QID_W  = 3;
  localparam int DATA_W = 8;
  localparam int FILL_W = 9;

  localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BADQ  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [QID_W-1:0]  queue_id;
    logic [DATA_W-1:0] data_in;
    logic              last_in;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] data_out;
    logic [FILL_W-1:0] fill_count;
    logic              last_out;
  } rsp_t;

endpackage

FILE: rtl/multi_queue_byte_fifo_top.sv
// ----------------------------------------------------------------------------
// multi_queue_byte_fifo_top: bank of independent circular byte queues
// Each request word pushes a byte into, or pops a byte from, one queue and
// returns one response word with status, popped byte and fill count.
// ----------------------------------------------------------------------------
// One request word is taken in every clock cycle (busy_o stays low), and its
// response word appears on rsp_o with rsp_valid_o high for exactly one cycle,
// the cycle after the request was taken. The response cannot be held off: a
// receiver must capture it in that cycle. The rate is set by the single
// storage RAM, which does one write (push) or one read (pop) per cycle with
// registered read data; pointers and counts live in flip-flops and update in
// the same cycle. Storage needs no clearing after reset: a pop only reads
// bytes that an earlier push wrote.
module multi_queue_byte_fifo_top
  import mqbf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  // Per-queue pointers and counts
  logic [PTR_W-1:0] rd_ptr_q [QUEUE_COUNT];
  logic [PTR_W-1:0] wr_ptr_q [QUEUE_COUNT];
  logic [CNT_W-1:0] cnt_q    [QUEUE_COUNT];

  // Byte storage
  logic [DATA_W-1:0] mem_q [MEM_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Response registers
  logic              rsp_valid_q;
  logic              pop_ok_q;
  status_e           status_q, status_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              last_q;

  logic              accept;
  logic              bad_q_id;
  logic [QIDX_W-1:0] qidx;
  logic [CNT_W-1:0]  cnt_sel, cnt_new;
  logic [PTR_W-1:0]  ptr_sel, ptr_next;
  logic              full, empty;
  logic              push_ok, pop_ok;
  logic [ADDR_W-1:0] addr;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Decode the request word against the selected queue
  assign bad_q_id = ({1'b0, req_i.queue_id} >= (QID_W + 1)'(QUEUE_COUNT));
  assign qidx     = bad_q_id ? '0 : req_i.queue_id[QIDX_W-1:0];
  assign cnt_sel  = cnt_q[qidx];
  assign full     = (cnt_sel == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_sel == '0);
  assign push_ok  = accept && !bad_q_id && (req_i.cmd == CMD_PUSH) && !full;
  assign pop_ok   = accept && !bad_q_id && (req_i.cmd == CMD_POP) && !empty;

  assign ptr_sel  = (req_i.cmd == CMD_PUSH) ? wr_ptr_q[qidx] : rd_ptr_q[qidx];
  assign ptr_next = (ptr_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_sel + 1'b1;
  assign addr     = ADDR_W'(int'(qidx) * QUEUE_DEPTH + int'(ptr_sel));

  // Work out status and count after the step
  always_comb begin
    cnt_new  = cnt_sel;
    status_d = ST_OK;
    if (bad_q_id) begin
      status_d = ST_BADQ;
    end else if (req_i.cmd == CMD_PUSH) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        cnt_new = cnt_sel + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        cnt_new = cnt_sel - 1'b1;
      end
    end
    fill_d = bad_q_id ? '0 : FILL_W'(cnt_new);
  end

  // Advance pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        cnt_q[i]    <= '0;
      end
    end else begin
      if (push_ok) begin
        wr_ptr_q[qidx] <= ptr_next;
        cnt_q[qidx]    <= cnt_new;
      end
      if (pop_ok) begin
        rd_ptr_q[qidx] <= ptr_next;
        cnt_q[qidx]    <= cnt_new;
      end
    end
  end

  // Write pushed bytes, read popped bytes
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[addr] <= req_i.data_in;
    end
    if (pop_ok) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Register the response valid and pop flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      pop_ok_q    <= 1'b0;
    end else begin
      rsp_valid_q <= accept;
      pop_ok_q    <= pop_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      fill_q   <= fill_d;
      last_q   <= req_i.last_in;
    end
  end

  assign rsp_valid_o         = rsp_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.data_out      = pop_ok_q ? rdata_q : '0;
  assign rsp_o.fill_count    = fill_q;
  assign rsp_o.last_out      = last_q;

  // A taken request gives a response in the next cycle, and only then
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_o)
    else $error("missing response after accepted request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !rsp_valid_o)
    else $error("response without accepted request");

  // Popped data only comes with an accepted pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.data_out != '0) |->
      (rsp_o.status == ST_OK && $past(req_i.cmd) == CMD_POP))
    else $error("data on a response that is not an accepted pop");

  // A bad queue number reports nothing held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == ST_BADQ) |-> (rsp_o.fill_count == '0))
    else $error("nonzero fill count for bad queue number");

  // Counts never pass the queue depth
  for (genvar g = 0; g < QUEUE_COUNT; g++) begin : g_cnt_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q[g] <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the multi-queue byte FIFO
// Drives push and pop request words: a short directed table first, then
// random software calls (runs of words into one queue) and random noise.
// A local model of the queue bank predicts each response word that the
// directed table does not type in; every word is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import mqbf_pkg::*;

  localparam int TOTAL_WORDS = 1250;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic rsp_valid_o;
  rsp_t rsp_o;

  multi_queue_byte_fifo_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  // Model state of the queue bank
  logic [DATA_W-1:0] bank_mem [QUEUE_COUNT][QUEUE_DEPTH];
  int unsigned       rd_ptr   [QUEUE_COUNT];
  int unsigned       wr_ptr   [QUEUE_COUNT];
  int unsigned       held     [QUEUE_COUNT];

  rsp_t exp_rsp_q [$];
  int   mismatches = 0;
  int   words_sent = 0;

  // Directed rows: response typed in where it is obvious, else predicted
  typedef struct {
    req_t w;
    bit   typed;
    rsp_t r;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{CMD_POP,  3'd0, 8'h00, 1'b1}, 1'b1, '{ST_EMPTY, 8'h00, 9'd0, 1'b1}},
    '{'{CMD_POP,  3'd3, 8'hFF, 1'b0}, 1'b1, '{ST_EMPTY, 8'h00, 9'd0, 1'b0}},
    '{'{CMD_PUSH, 3'd4, 8'hFF, 1'b1}, 1'b1, '{ST_BADQ,  8'h00, 9'd0, 1'b1}},
    '{'{CMD_POP,  3'd7, 8'h00, 1'b0}, 1'b1, '{ST_BADQ,  8'h00, 9'd0, 1'b0}},
    '{'{CMD_PUSH, 3'd0, 8'hFF, 1'b0}, 1'b1, '{ST_OK,    8'h00, 9'd1, 1'b0}},
    '{'{CMD_PUSH, 3'd0, 8'h00, 1'b1}, 1'b1, '{ST_OK,    8'h00, 9'd2, 1'b1}},
    '{'{CMD_POP,  3'd0, 8'h00, 1'b0}, 1'b1, '{ST_OK,    8'hFF, 9'd1, 1'b0}},
    '{'{CMD_POP,  3'd0, 8'h00, 1'b0}, 1'b1, '{ST_OK,    8'h00, 9'd0, 1'b0}},
    '{'{CMD_POP,  3'd0, 8'h00, 1'b1}, 1'b1, '{ST_EMPTY, 8'h00, 9'd0, 1'b1}},
    '{'{CMD_PUSH, 3'd3, 8'hA5, 1'b0}, 1'b1, '{ST_OK,    8'h00, 9'd1, 1'b0}},
    '{'{CMD_PUSH, 3'd1, 8'h5A, 1'b0}, 1'b1, '{ST_OK,    8'h00, 9'd1, 1'b0}},
    '{'{CMD_PUSH, 3'd2, 8'h3C, 1'b1}, 1'b1, '{ST_OK,    8'h00, 9'd1, 1'b1}},
    '{'{CMD_POP,  3'd1, 8'hFF, 1'b0}, 1'b1, '{ST_OK,    8'h5A, 9'd0, 1'b0}},
    '{'{CMD_PUSH, 3'd5, 8'h77, 1'b0}, 1'b1, '{ST_BADQ,  8'h00, 9'd0, 1'b0}},
    '{'{CMD_POP,  3'd6, 8'h88, 1'b1}, 1'b1, '{ST_BADQ,  8'h00, 9'd0, 1'b1}},
    '{'{CMD_POP,  3'd3, 8'h00, 1'b0}, 1'b1, '{ST_OK,    8'hA5, 9'd0, 1'b0}},
    '{'{CMD_POP,  3'd2, 8'h00, 1'b1}, 1'b1, '{ST_OK,    8'h3C, 9'd0, 1'b1}},
    '{'{CMD_PUSH, 3'd2, 8'hC3, 1'b0}, 1'b0, '0},
    '{'{CMD_PUSH, 3'd2, 8'h81, 1'b1}, 1'b0, '0},
    '{'{CMD_POP,  3'd2, 8'h7E, 1'b0}, 1'b0, '0},
    '{'{CMD_POP,  3'd2, 8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_POP,  3'd2, 8'h00, 1'b1}, 1'b0, '0}
  };

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Compute the response word of one request and advance the model
  function automatic rsp_t queue_step(input req_t w);
    rsp_t        r;
    int unsigned q;
    q = w.queue_id;
    r = '0;
    r.last_out = w.last_in;
    if (q >= QUEUE_COUNT) begin
      r.status = ST_BADQ;
    end else begin
      if (w.cmd == CMD_PUSH) begin
        if (held[q] >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          bank_mem[q][wr_ptr[q]] = w.data_in;
          wr_ptr[q] = (wr_ptr[q] + 1 >= QUEUE_DEPTH) ? 0 : wr_ptr[q] + 1;
          held[q]++;
          r.status = ST_OK;
        end
      end else begin
        if (held[q] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = bank_mem[q][rd_ptr[q]];
          rd_ptr[q] = (rd_ptr[q] + 1 >= QUEUE_DEPTH) ? 0 : rd_ptr[q] + 1;
          held[q]--;
          r.status = ST_OK;
        end
      end
      r.fill_count = FILL_W'(held[q]);
    end
    return r;
  endfunction

  // Offer one word, hold it until taken, then log its expected response
  task automatic send_word(input req_t w, input bit typed, input rsp_t typed_rsp);
    rsp_t pred;
    bit   steady;
    steady = (words_sent >= 500) && (words_sent < 800);
    if (!steady && $urandom_range(99) < 19) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= w;
    do @(posedge clk_i); while (busy_o);
    pred = queue_step(w);
    exp_rsp_q.push_back(typed ? typed_rsp : pred);
    words_sent++;
  endtask

  // One software call: a run of words into one queue, last one marked
  task automatic run_call(input cmd_e op, input int qid, input int len);
    req_t w;
    for (int k = 0; k < len; k++) begin
      w.cmd      = op;
      w.queue_id = QID_W'(qid);
      w.data_in  = DATA_W'($urandom);
      w.last_in  = (k == len - 1);
      send_word(w, 1'b0, '0);
    end
  endtask

  // Hold off the sender until every response word is back
  task automatic wait_for_drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (exp_rsp_q.size() != 0);
  endtask

  // Stimulus
  initial begin
    int   fill_q;
    int   pick;
    req_t w;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      rd_ptr[q] = 0;
      wr_ptr[q] = 0;
      held[q]   = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);
    end
    wait_for_drain();

    // Fill one queue past full, then drain it past empty
    fill_q = $urandom_range(QUEUE_COUNT - 1);
    run_call(CMD_PUSH, fill_q, QUEUE_DEPTH + 3);
    run_call(CMD_POP, fill_q, QUEUE_DEPTH + 3);

    while (words_sent < TOTAL_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // noise: any field value, bad queue numbers included
        w = req_t'($urandom);
        send_word(w, 1'b0, '0);
      end else if (pick < 12) begin
        run_call(cmd_e'($urandom_range(1)), $urandom_range(QUEUE_COUNT - 1),
                 $urandom_range(QUEUE_DEPTH - 8, QUEUE_DEPTH + 4));
      end else begin
        run_call(cmd_e'($urandom_range(1)), $urandom_range(QUEUE_COUNT - 1),
                 $urandom_range(1, 12));
      end
      if ($urandom_range(19) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Check each response word against the oldest expectation
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid_o) begin
      if (exp_rsp_q.size() == 0) begin
        $error("response word with none expected: %h", rsp_o);
        mismatches++;
      end else begin
        e = exp_rsp_q.pop_front();
        if (rsp_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp_o.status);
          mismatches++;
        end
        if (rsp_o.data_out !== e.data_out) begin
          $error("data_out: expected %0h, got %0h", e.data_out, rsp_o.data_out);
          mismatches++;
        end
        if (rsp_o.fill_count !== e.fill_count) begin
          $error("fill_count: expected %0d, got %0d", e.fill_count, rsp_o.fill_count);
          mismatches++;
        end
        if (rsp_o.last_out !== e.last_out) begin
          $error("last_out: expected %0b, got %0b", e.last_out, rsp_o.last_out);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
